### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### design/dpd_pkg.sv
// Types, constants and conversion functions for the date pair difference block.
package dpd_pkg;

    localparam int YearW    = 14;
    localparam int MonW     = 4;
    localparam int DayW     = 5;
    localparam int HourW    = 5;
    localparam int MinW     = 6;
    localparam int SecW     = 6;
    localparam int DiffW    = 39;
    localparam int DaysW    = 24;
    localparam int TodW     = 17;
    localparam int DDiffW   = 25;
    localparam int AbsW     = 24;
    localparam int ProdW    = 41;
    localparam int NumStages = 6;

    localparam int SecsPerDay   = 86400;
    localparam int SecsPerHour  = 3600;
    localparam int SecsPerMin   = 60;
    localparam int DaysPerYear  = 365;
    localparam int YearZeroDays = 366;
    localparam int Recip25      = 5243;
    localparam int Recip25Shift = 17;

    typedef struct packed {
        logic [YearW-1:0] year;
        logic [MonW-1:0]  month;
        logic [DayW-1:0]  day;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second;
    } t_date;

    typedef struct packed {
        logic             yzero;
        logic [22:0]      p365;
        logic [11:0]      p4;
        logic [7:0]       p100;
        logic [5:0]       p400;
        logic [7:0]       y4q;
        logic [5:0]       y16q;
        logic [YearW-1:0] year;
        logic [8:0]       dbm;
        logic             late;
        logic [DayW-1:0]  day;
        logic [TodW-1:0]  tod;
    } t_s1;

    function automatic logic [8:0] days_before(logic [MonW-1:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0, 4'd1: r = 9'd0;
            4'd2:       r = 9'd31;
            4'd3:       r = 9'd59;
            4'd4:       r = 9'd90;
            4'd5:       r = 9'd120;
            4'd6:       r = 9'd151;
            4'd7:       r = 9'd181;
            4'd8:       r = 9'd212;
            4'd9:       r = 9'd243;
            4'd10:      r = 9'd273;
            4'd11:      r = 9'd304;
            4'd12:      r = 9'd334;
            default:    r = 9'd365;
        endcase
        return r;
    endfunction

    function automatic t_s1 conv_stage1(t_date d);
        t_s1              s;
        logic [YearW-1:0] p;
        logic [24:0]      m_p4;
        logic [22:0]      m_p16;
        logic [24:0]      m_y4;
        logic [22:0]      m_y16;
        p      = d.year - YearW'(1);
        m_p4   = 25'(p[YearW-1:2]) * 25'(Recip25);
        m_p16  = 23'(p[YearW-1:4]) * 23'(Recip25);
        m_y4   = 25'(d.year[YearW-1:2]) * 25'(Recip25);
        m_y16  = 23'(d.year[YearW-1:4]) * 23'(Recip25);
        s.yzero = (d.year == '0);
        s.p365  = 23'(p) * 23'(DaysPerYear);
        s.p4    = p[YearW-1:2];
        s.p100  = m_p4[Recip25Shift +: 8];
        s.p400  = m_p16[Recip25Shift +: 6];
        s.y4q   = m_y4[Recip25Shift +: 8];
        s.y16q  = m_y16[Recip25Shift +: 6];
        s.year  = d.year;
        s.dbm   = days_before(d.month);
        s.late  = (d.month >= MonW'(3));
        s.day   = d.day;
        s.tod   = TodW'(d.hour) * TodW'(SecsPerHour) + TodW'(d.minute) * TodW'(SecsPerMin)
                + TodW'(d.second);
        return s;
    endfunction

    function automatic logic [DaysW-1:0] conv_stage2(t_s1 s);
        logic             div100;
        logic             div400;
        logic             leap;
        logic [DaysW-1:0] base;
        div100 = (s.year[1:0] == 2'd0) && ((12'(s.y4q) * 12'd25) == s.year[YearW-1:2]);
        div400 = (s.year[3:0] == 4'd0) && ((10'(s.y16q) * 10'd25) == s.year[YearW-1:4]);
        leap   = (s.year[1:0] == 2'd0) && (!div100 || div400);
        base   = s.yzero ? (DaysW'(0) - DaysW'(YearZeroDays))
                         : (DaysW'(s.p365) + DaysW'(s.p4) - DaysW'(s.p100) + DaysW'(s.p400));
        return base + DaysW'(s.dbm) + DaysW'(leap && s.late) + DaysW'(s.day) - DaysW'(1);
    endfunction

endpackage

### design/dpd_if.sv
// Valid/ready channel interfaces for date pair beats and difference beats.
interface dpd_in_if;
    logic                      valid;
    logic                      ready;
    logic [dpd_pkg::YearW-1:0] first_year;
    logic [dpd_pkg::MonW-1:0]  first_month;
    logic [dpd_pkg::DayW-1:0]  first_day;
    logic [dpd_pkg::HourW-1:0] first_hour;
    logic [dpd_pkg::MinW-1:0]  first_minute;
    logic [dpd_pkg::SecW-1:0]  first_second;
    logic [dpd_pkg::YearW-1:0] second_year;
    logic [dpd_pkg::MonW-1:0]  second_month;
    logic [dpd_pkg::DayW-1:0]  second_day;
    logic [dpd_pkg::HourW-1:0] second_hour;
    logic [dpd_pkg::MinW-1:0]  second_minute;
    logic [dpd_pkg::SecW-1:0]  second_sec;

    modport source (
        output valid, first_year, first_month, first_day, first_hour, first_minute,
               first_second, second_year, second_month, second_day, second_hour,
               second_minute, second_sec,
        input  ready
    );
    modport sink (
        input  valid, first_year, first_month, first_day, first_hour, first_minute,
               first_second, second_year, second_month, second_day, second_hour,
               second_minute, second_sec,
        output ready
    );
endinterface

interface dpd_out_if;
    logic                      valid;
    logic                      ready;
    logic [dpd_pkg::DiffW-1:0] difference;

    modport source (output valid, difference, input ready);
    modport sink (input valid, difference, output ready);
endinterface

### design/date_pair_difference.sv
// Top level: absolute difference of two Gregorian date-times, in seconds or whole days.
//
// Each beat carries two date-times; each is turned into a day count since
// 0001-01-01 and a second-of-day count, the two are subtracted, and the
// difference is given in seconds or, with days_mode set, in whole days.
// The block takes one beat per cycle while its output is not stalled, and
// delivers each result through a six-stage pipeline: year division and table
// lookup, day count, subtraction and normalisation, magnitude, the multiply
// by 86400, and the final add and unit select. A stalled output holds every
// full stage, while bubbles behind it close up; no beat is lost or repeated.
// The user must write days_mode through the configuration port while no beat is in flight; it is unchecked.
`include "assert_macros.svh"

module date_pair_difference (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    dpd_in_if.sink     i_src,
    dpd_out_if.source  o_res
);

    typedef struct packed {
        dpd_pkg::t_s1 a;
        dpd_pkg::t_s1 b;
    } t_st1;

    typedef struct packed {
        logic [dpd_pkg::DaysW-1:0] days_a;
        logic [dpd_pkg::DaysW-1:0] days_b;
        logic [dpd_pkg::TodW-1:0]  tod_a;
        logic [dpd_pkg::TodW-1:0]  tod_b;
    } t_st2;

    typedef struct packed {
        logic signed [dpd_pkg::DDiffW-1:0] days;
        logic [dpd_pkg::TodW-1:0]          tod;
    } t_st3;

    typedef struct packed {
        logic                     neg;
        logic [dpd_pkg::AbsW-1:0] abs_days;
        logic [dpd_pkg::TodW-1:0] tod;
    } t_st4;

    typedef struct packed {
        logic                      neg;
        logic [dpd_pkg::ProdW-1:0] prod;
        logic [dpd_pkg::AbsW-1:0]  whole_days;
        logic [dpd_pkg::TodW-1:0]  tod;
    } t_st5;

    logic                            r_days_mode;
    logic [dpd_pkg::NumStages-1:0]   r_vld;
    logic [dpd_pkg::NumStages-1:0]   s_adv;
    t_st1                            r_s1;
    t_st2                            r_s2;
    t_st3                            r_s3;
    t_st4                            r_s4;
    t_st5                            r_s5;
    logic [dpd_pkg::DiffW-1:0]       r_res;

    dpd_pkg::t_date                  s_date_a;
    dpd_pkg::t_date                  s_date_b;
    logic signed [dpd_pkg::DDiffW-1:0] s3_d;
    logic signed [18:0]              s3_t;
    logic signed [18:0]              s3_tn;
    logic signed [dpd_pkg::DDiffW-1:0] s3_dn;
    logic [dpd_pkg::DDiffW-1:0]      s4_abs;
    logic [dpd_pkg::ProdW-1:0]       s6_secs;
    logic [dpd_pkg::DiffW-1:0]       n_res;

    always_comb begin
        s_adv[dpd_pkg::NumStages-1] = !r_vld[dpd_pkg::NumStages-1] || o_res.ready;
        for (int k = dpd_pkg::NumStages - 2; k >= 0; k--) begin
            s_adv[k] = !r_vld[k] || s_adv[k+1];
        end
    end

    assign i_src.ready      = s_adv[0];
    assign o_res.valid      = r_vld[dpd_pkg::NumStages-1];
    assign o_res.difference = r_res;

    assign s_date_a = '{year: i_src.first_year, month: i_src.first_month,
                        day: i_src.first_day, hour: i_src.first_hour,
                        minute: i_src.first_minute, second: i_src.first_second};
    assign s_date_b = '{year: i_src.second_year, month: i_src.second_month,
                        day: i_src.second_day, hour: i_src.second_hour,
                        minute: i_src.second_minute, second: i_src.second_sec};

    always_comb begin
        s3_d = {r_s2.days_a[dpd_pkg::DaysW-1], r_s2.days_a}
             - {r_s2.days_b[dpd_pkg::DaysW-1], r_s2.days_b};
        s3_t = {2'b00, r_s2.tod_a} - {2'b00, r_s2.tod_b};
        priority if (s3_t < -19'sd86400) begin
            s3_tn = s3_t + 19'sd172800;
            s3_dn = s3_d - 25'sd2;
        end else if (s3_t < 19'sd0) begin
            s3_tn = s3_t + 19'sd86400;
            s3_dn = s3_d - 25'sd1;
        end else if (s3_t >= 19'sd86400) begin
            s3_tn = s3_t - 19'sd86400;
            s3_dn = s3_d + 25'sd1;
        end else begin
            s3_tn = s3_t;
            s3_dn = s3_d;
        end
    end

    assign s4_abs  = r_s3.days[dpd_pkg::DDiffW-1] ? (dpd_pkg::DDiffW'(0) - r_s3.days)
                                                   : r_s3.days;
    assign s6_secs = r_s5.neg ? (r_s5.prod - dpd_pkg::ProdW'(r_s5.tod))
                              : (r_s5.prod + dpd_pkg::ProdW'(r_s5.tod));
    assign n_res   = r_days_mode ? dpd_pkg::DiffW'(r_s5.whole_days) : s6_secs[dpd_pkg::DiffW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_days_mode <= 1'b0;
            r_vld       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_days_mode <= i_cfg_wr_data;
            end
            if (s_adv[0]) begin
                r_vld[0] <= i_src.valid;
            end
            for (int k = 1; k < dpd_pkg::NumStages; k++) begin
                if (s_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            r_s1.a <= dpd_pkg::conv_stage1(s_date_a);
            r_s1.b <= dpd_pkg::conv_stage1(s_date_b);
        end
        if (s_adv[1]) begin
            r_s2.days_a <= dpd_pkg::conv_stage2(r_s1.a);
            r_s2.days_b <= dpd_pkg::conv_stage2(r_s1.b);
            r_s2.tod_a  <= r_s1.a.tod;
            r_s2.tod_b  <= r_s1.b.tod;
        end
        if (s_adv[2]) begin
            r_s3.days <= s3_dn;
            r_s3.tod  <= s3_tn[dpd_pkg::TodW-1:0];
        end
        if (s_adv[3]) begin
            r_s4.neg      <= r_s3.days[dpd_pkg::DDiffW-1];
            r_s4.abs_days <= s4_abs[dpd_pkg::AbsW-1:0];
            r_s4.tod      <= r_s3.tod;
        end
        if (s_adv[4]) begin
            r_s5.neg        <= r_s4.neg;
            r_s5.prod       <= dpd_pkg::ProdW'(r_s4.abs_days)
                             * dpd_pkg::ProdW'(dpd_pkg::SecsPerDay);
            r_s5.whole_days <= (r_s4.neg && r_s4.tod != '0)
                             ? (r_s4.abs_days - dpd_pkg::AbsW'(1)) : r_s4.abs_days;
            r_s5.tod        <= r_s4.tod;
        end
        if (s_adv[5]) begin
            r_res <= n_res;
        end
    end

    `ASSERT_IMPLIES(a_days_floor, i_clk, i_rst_n, r_vld[1],
        $signed(r_s2.days_a) >= -24'sd367 && $signed(r_s2.days_b) >= -24'sd367,
        "day count below year zero")
    `ASSERT_IMPLIES(a_tod_norm, i_clk, i_rst_n, r_vld[2],
        r_s3.tod < dpd_pkg::TodW'(dpd_pkg::SecsPerDay), "second of day not normalised")
    `ASSERT_IMPLIES(a_neg_nonzero, i_clk, i_rst_n, r_vld[3] && r_s4.neg,
        r_s4.abs_days != '0, "negative day difference with zero magnitude")
    `ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_vld[4] && !s_adv[4],
        r_vld[4] && $stable(r_s5.prod), "stalled stage lost its beat")

endmodule
